@@ rtl/core/kois_pkg.sv @@
// kois_pkg: shared types, constants and helpers of the Kepler orbit integrator.
// Used by kois_norm, kois_mul and kepler_orbit_integrator_step.
package kois_pkg;

  // Fixed-point format and iteration count
  localparam int FRAC_BITS    = 28;
  localparam int NEWTON_STEPS = 4;
  localparam int NIT_W        = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;

  // Squared radius floor is 1/16, as a bit index of the 2*FRAC_BITS square
  localparam int SMIN_BIT = 2 * FRAC_BITS - 4;

  // Shared multiplier widths
  localparam int MUL_W  = 35;
  localparam int PROD_W = 2 * MUL_W;

  // Step size register
  localparam int                STEP_W   = 24;
  localparam logic [STEP_W-1:0] STEP_RST = 24'd134218;

  // Newton constants, 30 fraction bits
  localparam logic [31:0] ONE30      = 32'h4000_0000;
  localparam logic [31:0] THREE30    = 32'hC000_0000;
  localparam logic [31:0] GUESS_LOW  = 32'd912680550;
  localparam logic [31:0] GUESS_HIGH = 32'd644245094;

  // Saturation bounds on the 48-bit accumulator
  localparam logic signed [47:0] I32_MAX = 48'sd2147483647;
  localparam logic signed [47:0] I32_MIN = -48'sd2147483648;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_mom_x;
    logic signed [31:0] load_mom_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_mom_x;
    logic signed [31:0] out_mom_y;
    logic               saturated;
  } out_t;

  // Normalizer result: clamp flag, mantissa, Newton seed and force shift
  typedef struct packed {
    logic        clamped;
    logic [31:0] m;
    logic [30:0] y0;
    logic [5:0]  sh;
  } norm_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // Clamp a wide sum to the 32-bit signed range
  function automatic sat_t sat32(input logic signed [47:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > I32_MAX) begin
      r.ovf = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < I32_MIN) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/kois_mul.sv @@
// kois_mul: the shared signed multiplier with a registered product.
// Depends on kois_pkg for operand widths.
module kois_mul (
  input  logic                                clk_i,
  input  logic signed [kois_pkg::MUL_W-1:0]   a_i,
  input  logic signed [kois_pkg::MUL_W-1:0]   b_i,
  output logic signed [kois_pkg::PROD_W-1:0]  p_o
);

  logic signed [kois_pkg::PROD_W-1:0] p_q;

  // One product per cycle, ready the cycle after issue
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/kois_norm.sv @@
// kois_norm: clamps the squared radius and normalizes it for the r^-1/2 Newton loop.
// Depends on kois_pkg for the format constants and norm_t.
module kois_norm (
  input  logic [63:0]     s_i,
  output kois_pkg::norm_t norm_o
);

  logic [63:0] s_c;
  logic        clamp;
  logic [5:0]  b;
  logic [5:0]  t;
  logic [5:0]  amt;
  logic [5:0]  sh;
  logic [63:0] m_full;

  // Floor at 1/16, then find the leading one above the floor
  always_comb begin
    s_c   = s_i;
    clamp = 1'b0;
    if (s_i < (64'd1 << kois_pkg::SMIN_BIT)) begin
      s_c   = 64'd1 << kois_pkg::SMIN_BIT;
      clamp = 1'b1;
    end
    b = 6'(kois_pkg::SMIN_BIT);
    for (int i = kois_pkg::SMIN_BIT; i < 64; i++) begin
      if (s_c[i]) b = 6'(i);
    end
  end

  // Even exponent keeps m in [1,4) with 30 fraction bits
  assign t      = b - 6'(kois_pkg::SMIN_BIT);
  assign amt    = b - 6'd30 - {5'd0, t[0]};
  assign m_full = s_c >> amt;
  assign sh     = 6'd24 + 6'd3 * {1'b0, t[5:1]};

  assign norm_o.clamped = clamp;
  assign norm_o.m       = m_full[31:0];
  assign norm_o.y0      = t[0] ? kois_pkg::GUESS_HIGH[30:0] : kois_pkg::GUESS_LOW[30:0];
  assign norm_o.sh      = sh;

endmodule

@@ rtl/core/kepler_orbit_integrator_step.sv @@
// Kepler two-body integrator: one explicit midpoint step per item, one shared multiplier.
// A load item writes the state and goes straight to S_WB to present its beat. A step item
// runs a force evaluation, a half kick and drift, a force evaluation at the midpoint, the
// full kick and S_WB, all on the single 35x35 multiplier; output stalls hold S_WB.
// One item at a time: in_stall_o is high until the beat is registered and S_IDLE returns.
// Reset: state and step size return to zero and 134218, no output beat pending.
// Depends on kois_pkg, kois_mul and kois_norm.
module kepler_orbit_integrator_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kois_pkg::STEP_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kois_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kois_pkg::out_t              out_data_o
);

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_SQX   = 23'h000002,
    S_SQY   = 23'h000004,
    S_NORM  = 23'h000008,
    S_INIT  = 23'h000010,
    S_N1    = 23'h000020,
    S_N2    = 23'h000040,
    S_N3    = 23'h000080,
    S_N4    = 23'h000100,
    S_C1    = 23'h000200,
    S_C2    = 23'h000400,
    S_C3    = 23'h000800,
    S_C4    = 23'h001000,
    S_C5    = 23'h002000,
    S_K1    = 23'h004000,
    S_K2    = 23'h008000,
    S_K3    = 23'h010000,
    S_K4    = 23'h020000,
    S_K5    = 23'h040000,
    S_P1    = 23'h080000,
    S_P2    = 23'h100000,
    S_P3    = 23'h200000,
    S_WB    = 23'h400000
  } state_e;

  state_e state_q, state_d;

  logic [kois_pkg::STEP_W-1:0] step_q;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [31:0] mom_x_q, mom_x_d, mom_y_q, mom_y_d;
  logic signed [31:0] qx_q, qx_d, qy_q, qy_d;
  logic signed [31:0] pmx_q, pmx_d, pmy_q, pmy_d, qnx_q, qnx_d, qny_q, qny_d;
  logic [63:0] sx_q, sx_d, s_q, s_d;
  logic [31:0] m_q, m_d;
  logic [30:0] y_q, y_d, c_q, c_d;
  logic [5:0]  sh_q, sh_d;
  logic signed [kois_pkg::MUL_W-1:0] fx_q, fx_d, fy_q, fy_d;
  logic flag_q, flag_d, pass_q, pass_d;
  logic [kois_pkg::NIT_W-1:0] nit_q, nit_d;
  kois_pkg::out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic signed [kois_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [kois_pkg::PROD_W-1:0] prod;
  logic signed [kois_pkg::PROD_W-1:0] prod_neg, frc_w, kick_h, kick_f;
  kois_pkg::norm_t norm;
  logic [31:0] t2_w, t2_c;
  logic [30:0] ynew_w;
  logic signed [47:0] acc_a, acc_b;
  kois_pkg::sat_t acc;
  logic signed [32:0] mid_x, mid_y;
  logic in_acc;

  kois_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  kois_norm u_norm (
    .s_i    (s_q),
    .norm_o (norm)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Product taps for the Newton loop, the force scaling and the kicks
  assign t2_w     = prod[61:30];
  assign t2_c     = (t2_w > kois_pkg::THREE30) ? kois_pkg::THREE30 : t2_w;
  assign ynew_w   = (prod[61:31] > kois_pkg::ONE30[30:0]) ?
                    kois_pkg::ONE30[30:0] : prod[61:31];
  assign prod_neg = -prod;
  assign frc_w    = prod_neg >>> sh_q;
  assign kick_h   = prod >>> (kois_pkg::FRAC_BITS + 1);
  assign kick_f   = prod >>> kois_pkg::FRAC_BITS;

  // Shared saturating adder for kicks and drifts
  always_comb begin
    acc_a = 48'(mom_x_q);
    acc_b = kick_f[47:0];
    unique case (state_q)
      S_K2:    begin acc_a = 48'(mom_x_q); acc_b = kick_h[47:0]; end
      S_K3:    begin acc_a = 48'(mom_y_q); acc_b = kick_h[47:0]; end
      S_K4:    acc_a = 48'(pos_x_q);
      S_K5:    acc_a = 48'(pos_y_q);
      S_P3:    acc_a = 48'(mom_y_q);
      default: acc_a = 48'(mom_x_q);
    endcase
  end
  assign acc   = kois_pkg::sat32(acc_a + acc_b);
  assign mid_x = (33'(pos_x_q) + 33'(qnx_q)) >>> 1;
  assign mid_y = (33'(pos_y_q) + 33'(acc.val)) >>> 1;

  // Sequencer and operand selection
  always_comb begin
    state_d     = state_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    mom_x_d     = mom_x_q;
    mom_y_d     = mom_y_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    pmx_d       = pmx_q;
    pmy_d       = pmy_q;
    qnx_d       = qnx_q;
    qny_d       = qny_q;
    sx_d        = sx_q;
    s_d         = s_q;
    m_d         = m_q;
    y_d         = y_q;
    c_d         = c_q;
    sh_d        = sh_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    flag_d      = flag_q;
    pass_d      = pass_q;
    nit_d       = nit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = kois_pkg::MUL_W'(qx_q);
    mul_b       = kois_pkg::MUL_W'(qx_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          flag_d = 1'b0;
          pass_d = 1'b0;
          if (in_data_i.op == kois_pkg::OP_STEP) begin
            qx_d    = pos_x_q;
            qy_d    = pos_y_q;
            state_d = S_SQX;
          end else begin
            pos_x_d = in_data_i.load_pos_x;
            pos_y_d = in_data_i.load_pos_y;
            mom_x_d = in_data_i.load_mom_x;
            mom_y_d = in_data_i.load_mom_y;
            state_d = S_WB;
          end
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: begin
        mul_a   = kois_pkg::MUL_W'(qy_q);
        mul_b   = kois_pkg::MUL_W'(qy_q);
        sx_d    = prod[63:0];
        state_d = S_NORM;
      end
      S_NORM: begin
        s_d     = sx_q + prod[63:0];
        state_d = S_INIT;
      end
      S_INIT: begin
        m_d     = norm.m;
        y_d     = norm.y0;
        sh_d    = norm.sh;
        flag_d  = flag_q | norm.clamped;
        nit_d   = '0;
        state_d = S_N1;
      end
      // Newton: y <- y * (3 - m*y*y) / 2
      S_N1: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, m_q}));
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, y_q}));
        state_d = S_N2;
      end
      S_N2: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, prod[61:30]}));
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, y_q}));
        state_d = S_N3;
      end
      S_N3: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, y_q}));
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, kois_pkg::THREE30 - t2_c}));
        state_d = S_N4;
      end
      S_N4: begin
        y_d   = ynew_w;
        nit_d = nit_q + 1'b1;
        if (nit_q == kois_pkg::NIT_W'(kois_pkg::NEWTON_STEPS - 1)) begin
          state_d = S_C1;
        end else begin
          state_d = S_N1;
        end
      end
      // c = y^3, then f = -q * c >> sh
      S_C1: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, y_q}));
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, y_q}));
        state_d = S_C2;
      end
      S_C2: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, prod[60:30]}));
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, y_q}));
        state_d = S_C3;
      end
      S_C3: begin
        c_d     = prod[60:30];
        mul_a   = kois_pkg::MUL_W'(qx_q);
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, prod[60:30]}));
        state_d = S_C4;
      end
      S_C4: begin
        fx_d    = frc_w[kois_pkg::MUL_W-1:0];
        mul_a   = kois_pkg::MUL_W'(qy_q);
        mul_b   = kois_pkg::MUL_W'($signed({1'b0, c_q}));
        state_d = S_C5;
      end
      S_C5: begin
        fy_d    = frc_w[kois_pkg::MUL_W-1:0];
        state_d = pass_q ? S_P1 : S_K1;
      end
      // Half kick, drift, midpoint
      S_K1: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, step_q}));
        mul_b   = fx_q;
        state_d = S_K2;
      end
      S_K2: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, step_q}));
        mul_b   = fy_q;
        pmx_d   = acc.val;
        flag_d  = flag_q | acc.ovf;
        state_d = S_K3;
      end
      S_K3: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, step_q}));
        mul_b   = kois_pkg::MUL_W'(pmx_q);
        pmy_d   = acc.val;
        flag_d  = flag_q | acc.ovf;
        state_d = S_K4;
      end
      S_K4: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, step_q}));
        mul_b   = kois_pkg::MUL_W'(pmy_q);
        qnx_d   = acc.val;
        flag_d  = flag_q | acc.ovf;
        state_d = S_K5;
      end
      S_K5: begin
        qny_d   = acc.val;
        flag_d  = flag_q | acc.ovf;
        qx_d    = mid_x[31:0];
        qy_d    = mid_y[31:0];
        pass_d  = 1'b1;
        state_d = S_SQX;
      end
      // Full kick at the midpoint force
      S_P1: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, step_q}));
        mul_b   = fx_q;
        state_d = S_P2;
      end
      S_P2: begin
        mul_a   = kois_pkg::MUL_W'($signed({1'b0, step_q}));
        mul_b   = fy_q;
        mom_x_d = acc.val;
        flag_d  = flag_q | acc.ovf;
        state_d = S_P3;
      end
      S_P3: begin
        mom_y_d = acc.val;
        flag_d  = flag_q | acc.ovf;
        pos_x_d = qnx_q;
        pos_y_d = qny_q;
        state_d = S_WB;
      end
      // Present the result beat once the output register is free
      S_WB: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.out_pos_x = pos_x_q;
          out_d.out_pos_y = pos_y_q;
          out_d.out_mom_x = mom_x_q;
          out_d.out_mom_y = mom_y_q;
          out_d.saturated = flag_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= kois_pkg::STEP_RST;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      mom_x_q     <= '0;
      mom_y_q     <= '0;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      pass_q      <= 1'b0;
      nit_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      mom_x_q     <= mom_x_d;
      mom_y_q     <= mom_y_d;
      out_valid_q <= out_valid_d;
      flag_q      <= flag_d;
      pass_q      <= pass_d;
      nit_q       <= nit_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    qx_q  <= qx_d;
    qy_q  <= qy_d;
    pmx_q <= pmx_d;
    pmy_q <= pmy_d;
    qnx_q <= qnx_d;
    qny_q <= qny_d;
    sx_q  <= sx_d;
    s_q   <= s_d;
    m_q   <= m_d;
    y_q   <= y_d;
    c_q   <= c_d;
    sh_q  <= sh_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    out_q <= out_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.op == kois_pkg::OP_STEP) |=> (state_q == S_SQX && !pass_q))
    else $error("step item did not start the first force pass");

  a_y_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_N1 || state_q == S_C1) |-> (y_q <= kois_pkg::ONE30[30:0]))
    else $error("Newton estimate above one");

  a_beat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && !(out_valid_q && out_stall_i)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result beat not presented");

endmodule
